// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the windowed climb rate block.
// Each macro forms one labeled concurrent assertion with an asynchronous low reset.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WCRA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WCRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/wcra_pkg.sv
// Package for the windowed climb rate block: widths, constants, types.
// Used by the interfaces, the history RAM wrapper user and the top level.
`default_nettype none

package wcra_pkg;

	localparam int HISTORY_DEPTH = 64;
	localparam int IDX_W         = $clog2(HISTORY_DEPTH);

	localparam int TIME_W = 32;
	localparam int ALT_W  = 24;
	localparam int WIN_W  = 16;
	localparam int RATE_W = 32;
	localparam int FRAC_W = 8;

	// Altitude difference, its magnitude scaled by the fraction bits, and divider steps.
	localparam int DIFF_W    = ALT_W + 1;
	localparam int NUM_W     = DIFF_W + FRAC_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(480);

	// Saturation bounds on the quotient magnitude.
	localparam logic [NUM_W-1:0] POS_LIMIT =
		{{(NUM_W-RATE_W+1){1'b0}}, {(RATE_W-1){1'b1}}};
	localparam logic [NUM_W-1:0] NEG_LIMIT = POS_LIMIT + NUM_W'(1);

	localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
	localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

	typedef struct packed {
		logic [TIME_W-1:0]       stamp;
		logic signed [ALT_W-1:0] altitude;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_SETUP,
		ST_DIVIDE,
		ST_FINISH
	} wcra_state_t;

endpackage

`default_nettype wire

// File: rtl/wcra_if.sv
// Valid/ready channel interfaces for samples in and climb rate results out.
// Depends on wcra_pkg for the field widths.
`default_nettype none

interface wcra_sample_if import wcra_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [TIME_W-1:0]       sample_time;
	logic signed [ALT_W-1:0] sample_altitude;

	modport source (output valid, output sample_time, output sample_altitude, input ready);
	modport sink   (input valid, input sample_time, input sample_altitude, output ready);
endinterface

interface wcra_result_if import wcra_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] climb_rate;
	logic                     rate_valid;
	logic                     zero_interval;

	modport source (output valid, output climb_rate, output rate_valid,
		output zero_interval, input ready);
	modport sink   (input valid, input climb_rate, input rate_valid,
		input zero_interval, output ready);
endinterface

`default_nettype wire

// File: rtl/wcra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module wcra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/windowed_climb_rate_average.sv
// Windowed climb rate average: history ring, sequential scan and bit-serial divider.
// Depends on wcra_pkg, the channel interfaces in wcra_if.sv and the RAM in wcra_ram.sv.
//
// Each accepted item (time, altitude) is stored in a ring of HISTORY_DEPTH samples and
// one result item follows it. The block finds the oldest stored sample whose time plus
// window_length reaches the current time and reports (altitude difference * 256) /
// (time difference), rounded toward zero and saturated to 32 bits, with rate_valid set.
// When no earlier sample lies in the window the rate is 0 and rate_valid is 0. A zero
// time difference gives rate 0 with zero_interval set. An item passes through the history
// scan, which reads one RAM entry per cycle over all HISTORY_DEPTH entries, a drain state
// for the registered read data, a setup state and, when an earlier sample is found at a
// nonzero time difference, the restoring divider, which produces one quotient bit per
// cycle over 33 steps, before the result is loaded. The input opens again in the cycle
// after the load, so a new item is taken only once the last result is loaded.
// The input is not ready while an item is in work; a result waiting in the output
// register does not hold off the next item, only the loading of the following result.
// Valid bits are cleared by reset directly, so there is no clearing pass. window_length
// may only be written while the block is idle.
`default_nettype none

module windowed_climb_rate_average import wcra_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [WIN_W-1:0] cfg_wdata,
	wcra_sample_if.sink           smp,
	wcra_result_if.source         res
);

	// Sequencer state.
	wcra_state_t state_q, state_d;

	// Configuration register.
	logic [WIN_W-1:0] window_q;

	// Ring bookkeeping: write pointer and one valid bit per entry.
	logic [IDX_W-1:0]         wp_q;
	logic [IDX_W-1:0]         wp_next;
	logic [HISTORY_DEPTH-1:0] valid_q;

	// Current item and the best candidate found so far.
	logic [TIME_W-1:0]       now_q;
	logic signed [ALT_W-1:0] alt_q;
	logic [TIME_W-1:0]       best_time_q;
	logic signed [ALT_W-1:0] best_alt_q;
	logic                    found_q;

	// Scan address counter and the read pipeline stage.
	logic [IDX_W-1:0] idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	// Divider registers.
	logic [NUM_W-1:0]     quo_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic                 zero_q;

	// Output register.
	logic                     res_valid_q;
	logic signed [RATE_W-1:0] rate_q;
	logic                     rate_valid_q;
	logic                     zero_interval_q;

	// Control strobes from the sequencer.
	logic accept;
	logic out_load;
	logic scan_last;
	logic div_last;
	logic go_divide;

	// History memory.
	entry_t wr_entry;
	entry_t rd_entry;

	// Datapath signals.
	logic                    in_window;
	logic                    is_older;
	logic                    take_entry;
	logic [TIME_W-1:0]       dt;
	logic signed [DIFF_W-1:0] da;
	logic [DIFF_W-1:0]       da_mag;
	logic [TIME_W:0]         shifted;
	logic [TIME_W+1:0]       trial;
	logic                    trial_ok;
	logic [RATE_W-1:0]       sat_rate;

	// The ring advances to the next entry, wrapping after the last one.
	assign wp_next = (wp_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wp_q + IDX_W'(1);

	assign wr_entry.stamp    = smp.sample_time;
	assign wr_entry.altitude = smp.sample_altitude;

	wcra_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_next),
		.wdata (wr_entry),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	// Sequencer: next state and strobes.
	always_comb begin
		state_d   = state_q;
		smp.ready = 1'b0;
		accept    = 1'b0;
		out_load  = 1'b0;
		scan_last = (idx_q == IDX_W'(HISTORY_DEPTH - 1));
		div_last  = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
		go_divide = found_q && (dt != '0);
		case (state_q)
			ST_IDLE: begin
				smp.ready = 1'b1;
				if (smp.valid) begin
					accept  = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = go_divide ? ST_DIVIDE : ST_FINISH;
			end
			ST_DIVIDE: begin
				if (div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// The result is loaded once the output register is free.
				if (!res_valid_q || res.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Candidate test on the entry read in the previous cycle. The sum is 33 bits wide,
	// so the window test never wraps. A strict compare keeps earlier winners on ties.
	assign in_window  = ({1'b0, rd_entry.stamp} + {{(TIME_W-WIN_W+1){1'b0}}, window_q})
		>= {1'b0, now_q};
	assign is_older   = rd_entry.stamp < best_time_q;
	assign take_entry = cmp_vld_s1 && valid_q[cmp_idx_s1] && in_window && is_older;

	// Differences against the chosen entry.
	assign dt     = now_q - best_time_q;
	assign da     = DIFF_W'(alt_q) - DIFF_W'(best_alt_q);
	assign da_mag = da[DIFF_W-1] ? DIFF_W'(-da) : DIFF_W'(da);

	// One restoring division step: shift in the next numerator bit, try the subtract.
	assign shifted  = {rem_q, quo_q[NUM_W-1]};
	assign trial    = {1'b0, shifted} - {2'b00, dvs_q};
	assign trial_ok = !trial[TIME_W+1];

	// Sign and saturation of the quotient magnitude.
	always_comb begin
		if (neg_q) begin
			sat_rate = (quo_q > NEG_LIMIT) ? RATE_MIN : RATE_W'(-quo_q[RATE_W-1:0]);
		end else begin
			sat_rate = (quo_q > POS_LIMIT) ? RATE_MAX : quo_q[RATE_W-1:0];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			wp_q        <= IDX_W'(HISTORY_DEPTH - 1);
			valid_q     <= '0;
			idx_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (accept) begin
				wp_q             <= wp_next;
				valid_q[wp_next] <= 1'b1;
			end
			if (state_q == ST_SCAN) begin
				idx_q <= idx_q + IDX_W'(1);
			end else begin
				idx_q <= '0;
			end
			cmp_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_DIVIDE) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q;
		if (accept) begin
			now_q       <= smp.sample_time;
			alt_q       <= smp.sample_altitude;
			// The search starts at the new sample itself.
			best_time_q <= smp.sample_time;
			best_alt_q  <= smp.sample_altitude;
			found_q     <= 1'b0;
		end else if (take_entry) begin
			best_time_q <= rd_entry.stamp;
			best_alt_q  <= rd_entry.altitude;
			found_q     <= 1'b1;
		end
		if (state_q == ST_SETUP) begin
			quo_q  <= {da_mag, {FRAC_W{1'b0}}};
			rem_q  <= '0;
			dvs_q  <= dt;
			neg_q  <= da[DIFF_W-1];
			zero_q <= found_q && (dt == '0);
		end else if (state_q == ST_DIVIDE) begin
			rem_q <= trial_ok ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], trial_ok};
		end
		if (out_load) begin
			rate_q          <= (found_q && !zero_q) ? sat_rate : '0;
			rate_valid_q    <= found_q;
			zero_interval_q <= zero_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.climb_rate    = rate_q;
	assign res.rate_valid    = rate_valid_q;
	assign res.zero_interval = zero_interval_q;

endmodule

`default_nettype wire

// File: rtl/wcra_checker.sv
// Port-level checker for the windowed climb rate block, bound to its top level.
// Depends on assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module wcra_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        smp_valid,
	input wire logic        smp_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [31:0] climb_rate,
	input wire logic        rate_valid,
	input wire logic        zero_interval
);

	// A result item waiting on the sink keeps its fields.
	`WCRA_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(climb_rate) && $stable(rate_valid) && $stable(zero_interval), "result changed while stalled")

	// Every item takes many cycles, so the input closes right after an acceptance.
	`WCRA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, smp_valid && smp_ready, !smp_ready, "input ready right after an accepted item")

	// A zero interval only comes with a chosen older sample and a zero rate.
	`WCRA_ASSERT_SAME(a_zero_rate, clk, arst_n, res_valid && zero_interval, rate_valid && (climb_rate == 32'd0), "zero interval with nonzero rate or no sample")

	// Without an older sample in the window the rate is zero.
	`WCRA_ASSERT_SAME(a_no_sample_rate, clk, arst_n, res_valid && !rate_valid, (climb_rate == 32'd0) && !zero_interval, "rate reported without an older sample")

endmodule

bind windowed_climb_rate_average wcra_checker u_wcra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.smp_valid     (smp.valid),
	.smp_ready     (smp.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.climb_rate    (res.climb_rate),
	.rate_valid    (res.rate_valid),
	.zero_interval (res.zero_interval)
);

`default_nettype wire

// File: dv/windowed_climb_rate_average_checker.sv
// Checker for the windowed climb rate block: watches the sample, result and register ports.
// Keeps its own history ring, predicts each climb rate item and compares every result item.
// Depends on wcra_pkg and the channel interfaces in wcra_if.sv.
module windowed_climb_rate_average_checker import wcra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [WIN_W-1:0] cfg_wdata,
	wcra_sample_if           smp,
	wcra_result_if           res,
	output int               err_count,
	output int               outstanding,
	output int               rated_count,
	output int               saturated_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [RATE_W-1:0] climb_rate;
		logic                     rate_valid;
		logic                     zero_interval;
	} climb_result_t;

	localparam int MAX_PRINTED = 50;

	logic [TIME_W-1:0]       hist_time [HISTORY_DEPTH];
	logic signed [ALT_W-1:0] hist_alt [HISTORY_DEPTH];
	logic                    hist_valid [HISTORY_DEPTH];
	int                      head;
	logic [WIN_W-1:0]        window_len;
	climb_result_t           pending_rates [$];
	climb_result_t           want;
	int                      result_num;

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINTED)
			$display("[%0t] result item %0d: %s", $realtime, result_num, msg);
		err_count++;
	endtask

	// Stores the new sample, then picks the oldest in-window entry; ties stay on
	// the new entry first and otherwise on the lowest index.
	function automatic climb_result_t predict_climb(input logic [TIME_W-1:0] now,
			input logic signed [ALT_W-1:0] alt);
		int            best;
		logic [31:0]   dt;
		longint        diff;
		longint        quot;
		climb_result_t r;
		head = (head == HISTORY_DEPTH - 1) ? 0 : head + 1;
		hist_time[head]  = now;
		hist_alt[head]   = alt;
		hist_valid[head] = 1'b1;
		best = head;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			if (hist_valid[i] && ({1'b0, hist_time[i]} + 33'(window_len) >= {1'b0, now}) &&
					hist_time[i] < hist_time[best])
				best = i;
		end
		r = '0;
		if (best != head) begin
			dt = now - hist_time[best];
			r.rate_valid = 1'b1;
			if (dt == 0) begin
				r.zero_interval = 1'b1;
			end else begin
				diff = longint'(alt) - longint'(hist_alt[best]);
				quot = (diff * 256) / longint'({32'b0, dt});
				if (quot > longint'(32'sh7FFF_FFFF)) begin
					quot = longint'(32'sh7FFF_FFFF);
					saturated_count++;
				end else if (quot < -longint'(64'h8000_0000)) begin
					quot = -longint'(64'h8000_0000);
					saturated_count++;
				end
				r.climb_rate = quot[31:0];
			end
			rated_count++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (hist_valid[i]) hist_valid[i] = 1'b0;
			head            = HISTORY_DEPTH - 1;
			window_len      = WINDOW_RESET;
			pending_rates.delete();
			err_count       = 0;
			rated_count     = 0;
			saturated_count = 0;
			result_num      = 0;
			outstanding    <= 0;
		end else begin
			if (cfg_we)
				window_len = cfg_wdata;
			if (smp.valid && smp.ready)
				pending_rates.push_back(predict_climb(smp.sample_time, smp.sample_altitude));
			if (res.valid && res.ready) begin
				if (pending_rates.size() == 0) begin
					report_mismatch("arrived with no sample waiting for it");
				end else begin
					want = pending_rates.pop_front();
					if (res.climb_rate !== want.climb_rate)
						report_mismatch($sformatf("climb_rate %0d, expected %0d",
							res.climb_rate, want.climb_rate));
					if (res.rate_valid !== want.rate_valid)
						report_mismatch($sformatf("rate_valid %b, expected %b",
							res.rate_valid, want.rate_valid));
					if (res.zero_interval !== want.zero_interval)
						report_mismatch($sformatf("zero_interval %b, expected %b",
							res.zero_interval, want.zero_interval));
				end
				result_num++;
			end
			outstanding <= pending_rates.size();
		end
	end

endmodule

// File: dv/windowed_climb_rate_average_tb.sv
// Testbench top for the windowed climb rate block: clock, reset, stimulus and verdict.
// Depends on wcra_pkg, wcra_if.sv, the block itself and windowed_climb_rate_average_checker.
module windowed_climb_rate_average_tb import wcra_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// The settle time outlasts the work on one item from acceptance to its loaded result,
	// so the block has nothing left in work at its end.
	localparam int SETTLE_CYCLES = 120;
	// The long receiver hold-off; it must stay well below the watchdog limit.
	localparam int HOLD_CYCLES   = 1500;
	// Cycles with no item accepted on either channel before the run is abandoned.
	localparam int STALL_LIMIT   = 20000;
	localparam int PHASE_COUNT   = 6;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [WIN_W-1:0] cfg_wdata;

	wcra_sample_if smp_ch ();
	wcra_result_if res_ch ();

	int err_count;
	int outstanding;
	int rated_count;
	int saturated_count;

	// Knobs shared between the stimulus and the receiver process.
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int hold_served;
	int hold_left;
	int idle_cycles;

	// Stimulus state: the running sample time, altitude and the window now set.
	logic [TIME_W-1:0]       cur_time;
	logic signed [ALT_W-1:0] cur_alt;
	logic [WIN_W-1:0]        cur_window;
	int                      samples_sent;
	int                      windows_used;

	// Items per phase and idling per phase: the sender idles lightly while the
	// receiver idles heavily, then the other way round, then neither idles.
	int phase_items [PHASE_COUNT] = '{350, 100, 350, 150, 400, 350};
	int phase_send  [PHASE_COUNT] = '{7, 7, 45, 45, 0, 0};
	int phase_recv  [PHASE_COUNT] = '{45, 45, 7, 7, 0, 0};

	windowed_climb_rate_average dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.smp       (smp_ch),
		.res       (res_ch)
	);

	windowed_climb_rate_average_checker checker_inst (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.smp             (smp_ch),
		.res             (res_ch),
		.err_count       (err_count),
		.outstanding     (outstanding),
		.rated_count     (rated_count),
		.saturated_count (saturated_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random back-pressure, plus a long hold-off whenever the stimulus
	// asks for one. The hold is counted here so that the sender keeps offering
	// items meanwhile and the block backs up into its input.
	initial begin
		res_ch.ready = 1'b0;
		hold_served  = 0;
		hold_left    = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: any accepted item on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("windowed_climb_rate_average test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offers one sample item after a random number of idle cycles and returns in
	// the time step of its acceptance. Valid stays high when the next item follows
	// at once, so it is never lowered and raised in the same step.
	task automatic send_item(input logic [TIME_W-1:0] t, input logic signed [ALT_W-1:0] a);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			smp_ch.valid <= 1'b0;
			@(posedge clk);
		end
		smp_ch.valid           <= 1'b1;
		smp_ch.sample_time     <= t;
		smp_ch.sample_altitude <= a;
		do
			@(posedge clk);
		while (!smp_ch.ready);
		samples_sent++;
	endtask

	// Stops offering items, waits until every expected result item has come, and
	// then lets the block settle so that a register write finds it idle.
	task automatic drain_block();
		smp_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [WIN_W-1:0] w);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we     <= 1'b0;
		cur_window  = w;
		windows_used++;
	endtask

	initial begin
		int roll;
		int step;
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_wdata              = '0;
		smp_ch.valid           = 1'b0;
		smp_ch.sample_time     = '0;
		smp_ch.sample_altitude = '0;
		hold_requests          = 0;
		samples_sent           = 0;
		windows_used           = 1;
		cur_window             = WINDOW_RESET;
		send_idle_pct          = phase_send[0];
		recv_idle_pct          = phase_recv[0];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run at the reset window of 480.
		// The first sample has nothing older, and an equal time keeps the new entry.
		send_item(32'd100, 24'sd0);
		send_item(32'd100, 24'sd500);
		// Both entries at time 100 tie; the lowest index wins.
		send_item(32'd116, 24'sd1000);
		send_item(32'd117, -24'sd8388608);
		send_item(32'd118, 24'sd8388607);
		// Beyond the window nothing older qualifies; then a one-unit step with the
		// full altitude swing saturates high, and the reverse saturates low.
		send_item(32'd1000, -24'sd8388608);
		send_item(32'd1001, 24'sd8388607);
		send_item(32'd2000, 24'sd8388607);
		send_item(32'd2001, -24'sd8388608);
		// Entry time plus window exactly equal to the current time still counts,
		// one past it does not.
		send_item(32'd2481, 24'sd0);
		send_item(32'd2482, 24'sd77);
		// A time that goes backwards: only entries below it can be chosen.
		send_item(32'd2400, 24'sd100);
		send_item(32'd2399, -24'sd1);
		// Near the top of the time range the window sum needs its 33rd bit.
		send_item(32'hFFFF_FF00, 24'sd0);
		send_item(32'hFFFF_FFFF, 24'sd12345);
		send_item(32'hFFFF_FFFF, -24'sd12345);
		// Time zero after the top: no entry is older.
		send_item(32'd0, 24'sd0);
		send_item(32'd1, 24'sd3);
		send_item(32'd3, -24'sd5);
		drain_block();

		cur_time = 32'd5000;
		cur_alt  = '0;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: set_window(16'hFFFF);
				1: set_window(16'd0);
				2: set_window(WIN_W'($urandom_range(1, 2000)));
				3: set_window(16'd1);
				4: set_window(WINDOW_RESET);
				default: set_window(WIN_W'($urandom_range(0, 65535)));
			endcase
			send_idle_pct = phase_send[p];
			recv_idle_pct = phase_recv[p];
			// Long receiver hold-off at the start of the first random phase.
			if (p == 0)
				hold_requests <= hold_requests + 1;
			for (int n = 0; n < phase_items[p]; n++) begin
				// Once in the middle, the sender waits for every outstanding result.
				if (p == 2 && n == 100)
					drain_block();
				// Mostly small forward steps so that many entries share the window,
				// with equal times, jumps past the window, steps backwards and visits
				// to the top of the time range mixed in.
				roll = $urandom_range(0, 99);
				if (roll < 10) begin
					cur_time = cur_time;
				end else if (roll < 80) begin
					cur_time = cur_time + $urandom_range(1, int'(cur_window) / 8 + 2);
				end else if (roll < 90) begin
					cur_time = cur_time + $urandom_range(int'(cur_window) / 2,
						int'(cur_window) + 2);
				end else if (roll < 95) begin
					cur_time = cur_time + $urandom();
				end else if (roll < 98) begin
					cur_time = cur_time - $urandom_range(0, int'(cur_window) + 10);
				end else begin
					cur_time = 32'hFFFF_FFFF - $urandom_range(0, 3 * int'(cur_window) + 100);
				end
				// Altitude mostly drifts, sometimes takes any value or an extreme.
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					step    = int'($urandom_range(0, 4000)) - 2000;
					cur_alt = cur_alt + step[ALT_W-1:0];
				end else if (roll < 90) begin
					cur_alt = ALT_W'($urandom());
				end else if (roll < 95) begin
					cur_alt = 24'sh7F_FFFF;
				end else begin
					cur_alt = 24'sh80_0000;
				end
				send_item(cur_time, cur_alt);
			end
			drain_block();
		end

		$display("Sent %0d samples under %0d window settings, with heavy and light back-pressure.",
			samples_sent, windows_used);
		$display("%0d results used an older in-window sample, %0d of them saturated.",
			rated_count, saturated_count);
		if (err_count == 0) begin
			$display("windowed_climb_rate_average test passed");
		end else begin
			$display("%0d mismatches", err_count);
			$display("windowed_climb_rate_average test failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/wcra_pkg.sv
rtl/wcra_if.sv
rtl/wcra_ram.sv
rtl/windowed_climb_rate_average.sv
rtl/wcra_checker.sv
dv/windowed_climb_rate_average_checker.sv
dv/windowed_climb_rate_average_tb.sv
